>>> sv/rrtd_pkg.sv
// ----------------------------------------------------------------------------
// rrtd_pkg
// shared types and codes of the round-robin task dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package rrtd_pkg;

   localparam int BUDGET_W = 16;
   localparam int SLOT_W   = 4;

   // request codes
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_SELECT = 2'd1;
   localparam logic [1:0] REQ_REPORT = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [BUDGET_W-1:0] run_budget;
      logic                run_forever;
      logic [SLOT_W-1:0]   report_slot;
      logic                task_failed;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] granted_slot;
   } rsp_item_type;

   // one entry of the slot table
   typedef struct packed {
      logic                unlimited;
      logic [BUDGET_W-1:0] budget;
   } slot_entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REPORT,
      S_DONE
   } engine_state_type;

endpackage

`default_nettype wire

>>> sv/rrtd_ram.sv
// ----------------------------------------------------------------------------
// rrtd_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rrtd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/rrtd_engine.sv
// ----------------------------------------------------------------------------
// rrtd_engine
// request sequencer: append, round-robin scan and outcome update of the table
// ----------------------------------------------------------------------------
`default_nettype none

module rrtd_engine #(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire rrtd_pkg::req_item_type                req_item,
   output logic                                       req_stall,
   output logic                                       res_valid,
   output rrtd_pkg::rsp_item_type                     res_item,
   input  wire logic                                  res_take,
   output logic                                       ram_we,
   output logic [((TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1)-1:0] ram_waddr,
   output rrtd_pkg::slot_entry_type                   ram_wdata,
   output logic [((TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1)-1:0] ram_raddr,
   input  wire rrtd_pkg::slot_entry_type              ram_rdata
);

   import rrtd_pkg::*;

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

   engine_state_type state_ff, state_in;
   logic [CW-1:0]    used_ff, used_in;
   logic [IW-1:0]    start_ff, start_in;
   logic [IW-1:0]    chk_ff, chk_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   req_item_type     op_ff, op_in;
   rsp_item_type     res_ff, res_in;

   logic          full;
   logic [IW-1:0] first_pos;
   logic [XW-1:0] rpt_wide;
   logic [XW-1:0] op_rpt_wide;
   logic          rpt_ok;
   logic [CW-1:0] chk_p1;
   logic [IW-1:0] nxt;
   logic [IW-1:0] start_wrap;
   logic          eligible;
   logic          last;
   logic [XW-1:0] used_slot_wide;
   logic [XW-1:0] chk_wide;

   assign full           = (used_ff == CW'(TASK_SLOTS));
   assign first_pos      = (CW'(start_ff) >= used_ff) ? '0 : start_ff;
   assign rpt_wide       = XW'(req_item.report_slot);
   assign op_rpt_wide    = XW'(op_ff.report_slot);
   assign rpt_ok         = (rpt_wide < XW'(used_ff));
   assign chk_p1         = CW'(chk_ff) + CW'(1);
   assign nxt            = (chk_p1 == used_ff) ? '0 : chk_p1[IW-1:0];
   assign start_wrap     = (chk_ff == IW'(TASK_SLOTS - 1)) ? '0 : chk_p1[IW-1:0];
   assign eligible       = ram_rdata.unlimited | (|ram_rdata.budget);
   assign last           = (cnt_ff == CW'(used_ff - CW'(1)));
   assign used_slot_wide = XW'(used_ff);
   assign chk_wide       = XW'(chk_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_item.req_type == REQ_SELECT && used_ff != '0) begin
                  state_in = S_SCAN;
               end else if (req_item.req_type == REQ_REPORT && rpt_ok) begin
                  state_in = S_REPORT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (eligible || last) begin
               state_in = S_DONE;
            end
         end
         S_REPORT: state_in = S_DONE;
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      res_valid = (state_ff == S_DONE);
      ram_we    = 1'b0;
      ram_waddr = used_ff[IW-1:0];
      ram_wdata = '{unlimited: req_item.run_forever, budget: req_item.run_budget};
      ram_raddr = chk_ff;
      used_in   = used_ff;
      start_in  = start_ff;
      chk_in    = chk_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      res_in    = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_item;
               unique case (req_item.req_type)
                  REQ_APPEND: begin
                     if (full) begin
                        res_in = '{status: ST_FULL, granted_slot: '0};
                     end else begin
                        ram_we  = 1'b1;
                        used_in = used_ff + CW'(1);
                        res_in  = '{status: ST_OK,
                                    granted_slot: used_slot_wide[SLOT_W-1:0]};
                     end
                  end
                  REQ_SELECT: begin
                     ram_raddr = first_pos;
                     chk_in    = first_pos;
                     cnt_in    = '0;
                     res_in    = '{status: ST_NONE, granted_slot: '0};
                  end
                  REQ_REPORT: begin
                     ram_raddr = rpt_wide[IW-1:0];
                     if (rpt_ok) begin
                        res_in = '{status: ST_OK, granted_slot: req_item.report_slot};
                     end else begin
                        res_in = '{status: ST_NONE, granted_slot: req_item.report_slot};
                     end
                  end
                  default: begin
                     res_in = '{status: ST_OK, granted_slot: '0};
                  end
               endcase
            end
         end
         S_SCAN: begin
            // data of chk_ff arrives now, the next slot is read meanwhile
            ram_raddr = nxt;
            chk_in    = nxt;
            cnt_in    = cnt_ff + CW'(1);
            if (eligible) begin
               start_in = start_wrap;
               res_in   = '{status: ST_OK, granted_slot: chk_wide[SLOT_W-1:0]};
            end else if (last) begin
               res_in = '{status: ST_NONE, granted_slot: '0};
            end
         end
         S_REPORT: begin
            ram_we    = 1'b1;
            ram_waddr = op_rpt_wide[IW-1:0];
            ram_wdata = ram_rdata;
            if (op_ff.task_failed) begin
               ram_wdata = '{unlimited: 1'b0, budget: '0};
            end else if (!ram_rdata.unlimited && (|ram_rdata.budget)) begin
               ram_wdata.budget = ram_rdata.budget - BUDGET_W'(1);
            end
         end
         S_DONE: begin
         end
      endcase
   end

   assign res_item = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         start_ff <= start_in;
      end
      chk_ff <= chk_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

>>> sv/round_robin_task_dispatcher_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_dispatcher_top
// table of task slots with append, round-robin select and outcome report
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one request item (append, select or report), rsp_* carries
//   exactly one result item per request. an item moves on a rising edge with
//   valid high and stall low.
//   one request is in work at a time. append, a report of an unfilled slot
//   and a select on an empty table go straight to the result; a report adds
//   a table update step, and a select visits k slots, k from 1 to slots
//   filled; the scan reads one table entry per cycle through the single
//   read port of the slot memory. the result enters the output register
//   when the work ends and the register is empty or being drained, and stays
//   there while rsp_stall is high; the next request is still taken meanwhile,
//   but its result is held inside until the register frees up.
//   reset empties the table and points the scan at slot 0; the slot memory
//   needs no clearing pass since read data of unfilled slots is never used.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_dispatcher_top #(
   parameter int TASK_SLOTS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rrtd_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rrtd_pkg::rsp_item_type      rsp_item
);

   import rrtd_pkg::*;

   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   // engine side
   logic           res_valid;
   rsp_item_type   res_item;
   logic           res_take;

   // slot memory port
   logic           ram_we;
   logic [IW-1:0]  ram_waddr;
   slot_entry_type ram_wdata;
   logic [IW-1:0]  ram_raddr;
   slot_entry_type ram_rdata;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   // sequencer; a read issued in a cycle that writes is never used, so no forwarding
   rrtd_engine #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .res_valid (res_valid),
      .res_item  (res_item),
      .res_take  (res_take),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // budget and forever mark of each slot
   rrtd_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // load a finished result when the register is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = res_take ? res_item : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // after reset the block is empty and ready for a request
   a_reset_clean : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

   // only one request in work at a time
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in work");

   // a handed-over result leaves the engine and shows up at the output
   a_result_moves : assert property (@(posedge clock) disable iff (reset)
      res_take |=> (!res_valid && rsp_valid))
      else $error("result not moved into output register");

endmodule

`default_nettype wire

>>> verif/tb_round_robin_task_dispatcher_top.sv
// ----------------------------------------------------------------------------
// tb_round_robin_task_dispatcher_top
// self-checking testbench of the round-robin task dispatcher
// ----------------------------------------------------------------------------
// request items go in through a valid/stall port and are run through a
// dispatch predictor at the moment they are accepted. each accepted result
// is checked field by field against the oldest prediction. a directed part
// covers the empty table, the first appends, wrap of the scan, the report
// rules and a table with nothing eligible. a long random part then fills
// the table, grants and reports, with random idling on both sides for most
// of it. a final part kills every slot and checks table full and nothing eligible again.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_round_robin_task_dispatcher_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrtd_pkg::*;

   localparam int TASK_SLOTS = 16;

   // request code with no action defined
   localparam logic [1:0] REQ_UNDEF = 2'd3;

   localparam int IDLE_PCT    = 12;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   // idling of both sides on or off
   bit idle_on;

   int unsigned quiet_cycles = 0;
   int unsigned fail_count   = 0;
   int unsigned n_requests   = 0;
   int unsigned n_results    = 0;
   int unsigned n_grants     = 0;
   int unsigned n_full       = 0;
   int unsigned n_none       = 0;

   // results predicted for accepted requests, oldest first
   rsp_item_type pending_rsp[$];

   // predicted slot table
   logic [4:0]          tbl_used;
   logic [BUDGET_W-1:0] tbl_budget [TASK_SLOTS];
   logic                tbl_unlimited [TASK_SLOTS];
   logic [SLOT_W-1:0]   next_scan;
   // slot of the most recent grant, steers reports in the random part
   logic [SLOT_W-1:0]   last_grant;

   round_robin_task_dispatcher_top #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // dispatch predictor: updates the table copy and returns the result
   // ------------------------------------------------------------------------
   function automatic rsp_item_type predict_dispatch(input req_item_type r);
      rsp_item_type res;
      int           n;
      int           pos;
      int           slot;
      res.status       = ST_OK;
      res.granted_slot = '0;
      case (r.req_type)
         REQ_APPEND: begin
            if (tbl_used >= TASK_SLOTS) begin
               // table full, nothing changes
               res.status = ST_FULL;
            end else begin
               tbl_budget[tbl_used]    = r.run_budget;
               tbl_unlimited[tbl_used] = r.run_forever;
               res.granted_slot        = tbl_used[SLOT_W-1:0];
               tbl_used                = tbl_used + 5'd1;
            end
         end
         REQ_SELECT: begin
            n   = int'(tbl_used);
            pos = int'(next_scan);
            // stale start pointer restarts at slot 0
            if (pos >= n) pos = 0;
            res.status = ST_NONE;
            for (int k = 0; k < n; k++) begin
               if (tbl_unlimited[pos] || tbl_budget[pos] != '0) begin
                  res.status       = ST_OK;
                  res.granted_slot = SLOT_W'(pos);
                  last_grant       = SLOT_W'(pos);
                  next_scan        = (pos + 1 >= TASK_SLOTS) ? '0 : SLOT_W'(pos + 1);
                  n_grants++;
                  break;
               end
               pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
         end
         REQ_REPORT: begin
            slot             = int'(r.report_slot);
            res.granted_slot = r.report_slot;
            if (slot >= int'(tbl_used)) begin
               // unfilled slot is ignored
               res.status = ST_NONE;
            end else if (r.task_failed) begin
               tbl_budget[slot]    = '0;
               tbl_unlimited[slot] = 1'b0;
            end else if (!tbl_unlimited[slot] && tbl_budget[slot] != '0) begin
               tbl_budget[slot] = tbl_budget[slot] - 1'b1;
            end
         end
         default: begin
            // undefined code: no action, ok with slot 0
         end
      endcase
      return res;
   endfunction

   // predict on every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_rsp.push_back(predict_dispatch(req_item));
         n_requests++;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_rsp.size() == 0) begin
            $error("result with no request waiting: status %0d slot %0d",
                   rsp_item.status, rsp_item.granted_slot);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.granted_slot !== want.granted_slot) begin
               $error("granted_slot: expected %0d, actual %0d",
                      want.granted_slot, rsp_item.granted_slot);
               fail_count++;
            end
            if (want.status == ST_FULL) n_full++;
            else if (want.status == ST_NONE) n_none++;
         end
      end
   end

   // result side stalls at random while idling is on
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
   end

   // watchdog: cycles in a row with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_item_type make_item(input logic [1:0]          kind,
                                              input logic [BUDGET_W-1:0] budget,
                                              input logic                unlimited,
                                              input logic [SLOT_W-1:0]   slot,
                                              input logic                failed);
      req_item_type it;
      it.req_type    = kind;
      it.run_budget  = budget;
      it.run_forever = unlimited;
      it.report_slot = slot;
      it.task_failed = failed;
      return it;
   endfunction

   // send one item, at times with a random gap first while idling is on
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(6, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait for every predicted result to come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // mostly select/report traffic on live slots, slow table fill, some noise
   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  pick;
      it.req_type    = 2'($urandom_range(3));
      it.run_budget  = 16'($urandom);
      it.run_forever = 1'($urandom);
      it.report_slot = 4'($urandom);
      it.task_failed = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 4) begin
         // noise: any code, any slot, any outcome
      end else if (pick < 8 && tbl_used < TASK_SLOTS) begin
         it.req_type    = REQ_APPEND;
         it.run_forever = 1'b0;
         case ($urandom_range(3))
            0: it.run_budget = 16'($urandom_range(3));
            1: it.run_budget = 16'($urandom_range(400, 20));
            2: ;
            default: it.run_forever = 1'b1;
         endcase
      end else if (pick < 52) begin
         it.req_type = REQ_SELECT;
      end else begin
         // report, mostly of the task just granted, mostly a success
         it.req_type    = REQ_REPORT;
         it.task_failed = ($urandom_range(99) < 1);
         if ($urandom_range(99) < 70) it.report_slot = last_grant;
         else if (tbl_used != 0) it.report_slot = 4'($urandom_range(tbl_used - 1));
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // select and report on an empty table, undefined request code
   task automatic test_empty_table();
      send_item(make_item(REQ_SELECT, 16'hffff, 1'b1, 4'd0, 1'b0));
      send_item(make_item(REQ_REPORT, 16'h0000, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_REPORT, 16'hffff, 1'b1, 4'd15, 1'b1));
      send_item(make_item(REQ_UNDEF, 16'hffff, 1'b1, 4'd15, 1'b1));
      settle();
   endtask

   // first slots: budget extremes, forever mark, scan wrap, report rules
   task automatic test_first_slots();
      // slot 0 finite with no budget, slot 1 forever, slot 2 one run, slot 3 max
      send_item(make_item(REQ_APPEND, 16'h0000, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_APPEND, 16'h0000, 1'b1, 4'd0, 1'b0));
      send_item(make_item(REQ_APPEND, 16'h0001, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_APPEND, 16'hffff, 1'b0, 4'd0, 1'b0));
      // grants 1, 2, 3, then the start pointer is stale and wraps to 1, 2
      repeat (5) send_item(make_item(REQ_SELECT, '0, 1'b0, 4'd0, 1'b0));
      // last run of slot 2, success on empty finite slot, success on forever
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd2, 1'b0));
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd1, 1'b0));
      // failure clears a finite slot with budget left
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd3, 1'b1));
      send_item(make_item(REQ_SELECT, '0, 1'b0, 4'd0, 1'b0));
      // failure clears the forever mark, then nothing is eligible
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd1, 1'b1));
      send_item(make_item(REQ_SELECT, '0, 1'b0, 4'd0, 1'b0));
      // report of a slot not yet filled
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd7, 1'b0));
      send_item(make_item(REQ_UNDEF, '0, 1'b0, 4'd0, 1'b0));
      settle();
   endtask

   task automatic test_random_traffic(input int unsigned count);
      repeat (count) send_item(random_item());
      settle();
   endtask

   // fill whatever is left, overflow, kill every slot, nothing eligible
   task automatic test_drain_out();
      int unsigned fill;
      fill = TASK_SLOTS - tbl_used;
      repeat (fill) send_item(make_item(REQ_APPEND, 16'd5, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_APPEND, 16'hffff, 1'b1, 4'd15, 1'b1));
      for (int s = 0; s < TASK_SLOTS; s++) begin
         send_item(make_item(REQ_REPORT, '0, 1'b0, SLOT_W'(s), 1'b1));
      end
      send_item(make_item(REQ_SELECT, '0, 1'b0, 4'd0, 1'b0));
      send_item(make_item(REQ_REPORT, '0, 1'b0, 4'd4, 1'b0));
      send_item(make_item(REQ_APPEND, 16'hffff, 1'b1, 4'd0, 1'b0));
      settle();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      rsp_stall  = 1'b0;
      idle_on    = 1'b1;
      tbl_used   = '0;
      next_scan  = '0;
      last_grant = '0;
      for (int s = 0; s < TASK_SLOTS; s++) begin
         tbl_budget[s]    = '0;
         tbl_unlimited[s] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_first_slots();
      // random traffic, with a long stretch where neither side idles
      test_random_traffic(450);
      idle_on = 1'b0;
      test_random_traffic(300);
      idle_on = 1'b1;
      test_random_traffic(400);
      test_drain_out();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d predicted results never arrived", pending_rsp.size());
         fail_count++;
      end
      $display("covered %0d requests, %0d results: %0d grants, %0d table full, %0d none",
               n_requests, n_results, n_grants, n_full, n_none);
      $display("%0d field mismatches or stray results", fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
